// File: hdl/metaball_field_evaluator_macros.svh
// Assertion macros for the metaball field evaluator.
// Expects clk_i and rst_ni in the including module.
`ifndef METABALL_FIELD_EVALUATOR_MACROS_SVH
`define METABALL_FIELD_EVALUATOR_MACROS_SVH

// Same-cycle implication.
`define MFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mfe_pkg.sv
// Shared types and constants of the metaball field evaluator.
// No dependencies.
package mfe_pkg;

  localparam int MAX_BLOBS = 64;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_BLOBS);
  localparam int CNT_W     = $clog2(MAX_BLOBS + 1);

  localparam logic [16:0] ONE_FX     = 17'h1_0000;
  localparam logic [18:0] REACH_BASE = 19'(((12 << FRAC_BITS) + 5) / 10);
  localparam logic [18:0] SMOOTH_MAX = 19'(4 << FRAC_BITS);
  localparam logic [47:0] INV_NUM    = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] ISO_NUM    = 48'h0001_0000_0000;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_ADD_MUL,
    BS_ADD_SQ,
    BS_ADD_DIV,
    BS_ADD_WAIT,
    BS_QRY_WALK,
    BS_QRY_DRAIN,
    BS_ISO_SQ,
    BS_ISO_CUBE,
    BS_RESULT
  } back_state_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [30:0]        radius;
    logic signed [31:0] strength;
  } op_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [51:0]        r2;
    logic [47:0]        inv;
    logic signed [31:0] strength;
  } blob_t;

endpackage

// File: hdl/mfe_fifo.sv
// Two-entry queue of decoded operations between front and back.
// Depends on mfe_pkg.
module mfe_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfe_pkg::op_t  push_op_i,
  output logic          push_ready_o,
  input  logic          pop_i,
  output mfe_pkg::op_t  pop_op_o,
  output logic          pop_valid_o
);
  import mfe_pkg::*;

  op_t        slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_op_o     = slot_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_op_i;
  end

endmodule

// File: hdl/mfe_front.sv
// Input stage: accepts stream items, classifies the kind and clamps the radius.
// Depends on mfe_pkg.
module mfe_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [159:0]  s_axis_tdata,
  input  logic [1:0]    s_axis_tuser,
  output logic          push_o,
  output mfe_pkg::op_t  push_op_o,
  input  logic          push_ready_i
);
  import mfe_pkg::*;

  logic valid_q;
  op_t  op_q, op_d;
  logic accept;

  assign s_axis_tready = !valid_q || push_ready_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_o        = valid_q;
  assign push_op_o     = op_q;

  always_comb begin
    op_d.kind     = kind_e'(s_axis_tuser);
    op_d.x        = s_axis_tdata[31:0];
    op_d.y        = s_axis_tdata[63:32];
    op_d.z        = s_axis_tdata[95:64];
    op_d.radius   = (s_axis_tdata[126:96] == 31'd0) ? 31'd1 : s_axis_tdata[126:96];
    op_d.strength = s_axis_tdata[158:127];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) op_q <= op_d;
  end

endmodule

// File: hdl/mfe_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on mfe_pkg.
module mfe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] num_i,
  input  logic [51:0] den_i,
  output logic        done_o,
  output logic [47:0] quo_o
);
  import mfe_pkg::*;

  logic [47:0] num_q, quo_q;
  logic [52:0] rem_q, rem_s;
  logic [51:0] den_q;
  logic [5:0]  step_q;
  logic        busy_q, done_q, ge;

  assign rem_s  = {rem_q[51:0], num_q[47]};
  assign ge     = (rem_s >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 6'd1;
      if (step_q == 6'd47) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[46:0], 1'b0};
      rem_q <= ge ? (rem_s - {1'b0, den_q}) : rem_s;
      quo_q <= {quo_q[46:0], ge};
    end
  end

endmodule

// File: hdl/mfe_back.sv
// Execution side: blob table, add sequence, pipelined query walk and iso level.
// Depends on mfe_pkg, mfe_div and the assertion macro header.
module mfe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [18:0]   smooth_i,
  input  mfe_pkg::op_t  op_i,
  input  logic          op_valid_i,
  output logic          pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [47:0]   m_axis_tdata,
  output logic [1:0]    m_axis_tuser
);
  import mfe_pkg::*;
  `include "metaball_field_evaluator_macros.svh"

  localparam int NSTG = 9;

  back_state_e state_q, state_d;
  op_t         op_q;
  status_e     status_q;
  logic [CNT_W-1:0] cnt_q, iss_q;
  logic [18:0] reach_q, smooth_c;
  logic [21:0] riso_q;
  logic [33:0] bigr_q;
  logic [51:0] r2_q;
  logic [67:0] bigr_sq;

  logic        div_start, div_done;
  logic [47:0] div_num, div_quo;
  logic [51:0] div_den;

  logic        rd_en, mem_we, out_load;
  blob_t       mem [MAX_BLOBS];
  blob_t       rd_q;

  logic [NSTG-1:0] vld_q;
  logic [32:0] dm_q [3];
  logic [32:0] dabs [3];
  logic [49:0] sq_q [3];
  logic [51:0] d2_q;
  logic [51:0] r2_p1, r2_p2;
  logic [47:0] inv_p1, inv_p2, inv_p3;
  logic signed [31:0] str_p1, str_p2, str_p3, str_p4, str_p5, str_p6, str_p7;
  logic        hit_p3, hit_p4, hit_p5, hit_p6, hit_p7, hit_p8;
  logic [49:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic [99:0] prod_c;
  logic [16:0] u_c, t_p5, t_p6, t2_p6, cube_p7;
  logic [33:0] tt_c, t2t_c;
  logic signed [49:0] sc_c;
  logic signed [33:0] term_p8;
  logic signed [47:0] acc_q;

  logic [16:0] iso_a, iso_a2_q, iso_q;
  logic [33:0] iso_aa, iso_a2a;
  logic [47:0] res_field;
  logic        out_valid_q;
  logic [47:0] out_field_q;
  logic [1:0]  out_status_q;

  mfe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign smooth_c = (smooth_i > SMOOTH_MAX) ? SMOOTH_MAX : smooth_i;
  assign bigr_sq  = bigr_q * bigr_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BS_IDLE: begin
        if (op_valid_i) begin
          case (op_i.kind)
            KIND_ADD:   state_d = (cnt_q == CNT_W'(MAX_BLOBS)) ? BS_RESULT : BS_ADD_MUL;
            KIND_QUERY: state_d = (cnt_q == '0) ? BS_RESULT : BS_QRY_WALK;
            default:    state_d = BS_RESULT;
          endcase
        end
      end
      BS_ADD_MUL:   state_d = BS_ADD_SQ;
      BS_ADD_SQ:    state_d = BS_ADD_DIV;
      BS_ADD_DIV:   state_d = BS_ADD_WAIT;
      BS_ADD_WAIT:  if (div_done) state_d = BS_RESULT;
      BS_QRY_WALK:  if (iss_q == cnt_q) state_d = BS_QRY_DRAIN;
      BS_QRY_DRAIN: if (vld_q == '0 && div_done) state_d = BS_ISO_SQ;
      BS_ISO_SQ:    state_d = BS_ISO_CUBE;
      BS_ISO_CUBE:  state_d = BS_RESULT;
      BS_RESULT:    if (!out_valid_q || m_axis_tready) state_d = BS_IDLE;
      default:      state_d = BS_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = (state_q == BS_IDLE) && op_valid_i;
    div_start = (pop_o && op_i.kind == KIND_QUERY && cnt_q != '0)
                || (state_q == BS_ADD_DIV);
    div_num   = (state_q == BS_ADD_DIV) ? INV_NUM : ISO_NUM;
    div_den   = (state_q == BS_ADD_DIV) ? r2_q : {30'd0, riso_q};
    rd_en     = (state_q == BS_QRY_WALK) && (iss_q != cnt_q);
    mem_we    = (state_q == BS_ADD_WAIT) && div_done;
    out_load  = (state_q == BS_RESULT) && (!out_valid_q || m_axis_tready);
    res_field = (op_q.kind == KIND_QUERY && status_q == ST_OK)
                ? (acc_q - {31'd0, iso_q}) : 48'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      cnt_q       <= '0;
      iss_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= {vld_q[NSTG-2:0], rd_en};
      if (pop_o) begin
        iss_q <= '0;
        if (op_i.kind == KIND_CLEAR) cnt_q <= '0;
      end else if (rd_en) begin
        iss_q <= iss_q + CNT_W'(1);
      end
      if (mem_we) cnt_q <= cnt_q + CNT_W'(1);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    reach_q <= REACH_BASE + smooth_c;
    riso_q  <= 22'(({19'd0, reach_q} * {19'd0, reach_q}) >> FRAC_BITS);
    if (pop_o) begin
      op_q  <= op_i;
      acc_q <= '0;
      if (op_i.kind == KIND_ADD && cnt_q == CNT_W'(MAX_BLOBS)) begin
        status_q <= ST_FULL;
      end else if (op_i.kind == KIND_QUERY && cnt_q == '0) begin
        status_q <= ST_EMPTY;
      end else begin
        status_q <= ST_OK;
      end
    end else if (vld_q[NSTG-1] && hit_p8) begin
      acc_q <= acc_q + {{14{term_p8[33]}}, term_p8};
    end
    if (state_q == BS_ADD_MUL) begin
      bigr_q <= 34'(({19'd0, op_q.radius} * {31'd0, reach_q}) >> FRAC_BITS);
    end
    if (state_q == BS_ADD_SQ) begin
      r2_q <= (bigr_sq[67:16] == 52'd0) ? 52'd1 : bigr_sq[67:16];
    end
    if (state_q == BS_ISO_SQ)   iso_a2_q <= iso_aa[32:16];
    if (state_q == BS_ISO_CUBE) iso_q    <= iso_a2a[32:16];
    if (out_load) begin
      out_field_q  <= res_field;
      out_status_q <= status_q;
    end
  end

  assign iso_a   = ONE_FX - div_quo[16:0];
  assign iso_aa  = iso_a * iso_a;
  assign iso_a2a = iso_a2_q * iso_a;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[IDX_W-1:0]] <= '{x: op_q.x, y: op_q.y, z: op_q.z, r2: r2_q,
                                 inv: div_quo, strength: op_q.strength};
    end
    if (rd_en) rd_q <= mem[iss_q[IDX_W-1:0]];
  end

  assign prod_c = {50'd0, pp_ll_q} + ({50'd0, pp_lh_q} << 24)
                + ({50'd0, pp_hl_q} << 26) + ({50'd0, pp_hh_q} << 50);
  assign u_c    = (prod_c[99:48] != '0) ? ONE_FX : prod_c[48:32];
  assign tt_c   = t_p5 * t_p5;
  assign t2t_c  = t2_p6 * t_p6;
  assign sc_c   = str_p7 * $signed({1'b0, cube_p7});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dabs[k] = dm_q[k][32] ? (33'd0 - dm_q[k]) : dm_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    dm_q[0] <= ({op_q.x[31], op_q.x} - {rd_q.x[31], rd_q.x}) ;
    dm_q[1] <= ({op_q.y[31], op_q.y} - {rd_q.y[31], rd_q.y}) ;
    dm_q[2] <= ({op_q.z[31], op_q.z} - {rd_q.z[31], rd_q.z}) ;
    r2_p1   <= rd_q.r2;
    inv_p1  <= rd_q.inv;
    str_p1  <= rd_q.strength;
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= 50'(({33'd0, dabs[k]} * {33'd0, dabs[k]}) >> FRAC_BITS);
    end
    r2_p2   <= r2_p1;
    inv_p2  <= inv_p1;
    str_p2  <= str_p1;
    d2_q    <= {2'd0, sq_q[0]} + {2'd0, sq_q[1]} + {2'd0, sq_q[2]};
    hit_p3  <= ({2'd0, sq_q[0]} + {2'd0, sq_q[1]} + {2'd0, sq_q[2]}) < r2_p2;
    inv_p3  <= inv_p2;
    str_p3  <= str_p2;
    pp_ll_q <= d2_q[25:0]  * inv_p3[23:0];
    pp_lh_q <= d2_q[25:0]  * inv_p3[47:24];
    pp_hl_q <= d2_q[51:26] * inv_p3[23:0];
    pp_hh_q <= d2_q[51:26] * inv_p3[47:24];
    hit_p4  <= hit_p3;
    str_p4  <= str_p3;
    t_p5    <= ONE_FX - u_c;
    hit_p5  <= hit_p4;
    str_p5  <= str_p4;
    t2_p6   <= tt_c[32:16];
    t_p6    <= t_p5;
    hit_p6  <= hit_p5;
    str_p6  <= str_p5;
    cube_p7 <= t2t_c[32:16];
    hit_p7  <= hit_p6;
    str_p7  <= str_p6;
    term_p8 <= sc_c[49:16];
    hit_p8  <= hit_p7;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_field_q;
  assign m_axis_tuser  = out_status_q;

  `MFE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_BLOBS), "blob count past table size")
  `MFE_ASSERT_NOW(a_acc_in_query, vld_q[NSTG-1],
                  state_q == BS_QRY_WALK || state_q == BS_QRY_DRAIN, "term outside query")
  `MFE_ASSERT_NEXT(a_write_once, mem_we, state_q == BS_RESULT, "table write not followed by result")

endmodule

// File: hdl/metaball_field_evaluator.sv
// Metaball field evaluator: one result item for every input item. Clear and unused kinds go
// straight to the result; an add waits on the 48-bit reciprocal from the one-bit-per-cycle
// divider; a query walks the table memory, reading one stored blob per cycle, while the same
// divider forms the iso level. Items queue two deep between the input stage and the
// execution side.
// Depends on mfe_pkg, mfe_front, mfe_fifo and mfe_back.
module metaball_field_evaluator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [18:0]  cfg_data_i,      // smoothness
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,    // pos_x, pos_y, pos_z, blob_radius, blob_strength
  input  logic [1:0]   s_axis_tuser,    // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,    // field_value
  output logic [1:0]   m_axis_tuser     // status
);
  import mfe_pkg::*;

  logic [18:0] smooth_q;
  logic        push, push_ready, pop, pop_valid;
  op_t         push_op, pop_op;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= '0;
    end else if (cfg_valid_i) begin
      smooth_q <= cfg_data_i;
    end
  end

  mfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .push_o       (push),
    .push_op_o    (push_op),
    .push_ready_i (push_ready)
  );

  mfe_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_op_i   (push_op),
    .push_ready_o(push_ready),
    .pop_i       (pop),
    .pop_op_o    (pop_op),
    .pop_valid_o (pop_valid)
  );

  mfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .smooth_i     (smooth_q),
    .op_i         (pop_op),
    .op_valid_i   (pop_valid),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule
